// File: src/csas_pkg.sv
// Shared constants, codes, state type and controller/datapath link structs for the
// conversion slot allocator and scheduler; no dependencies. All but csas_ram import it.

package csas_pkg;

    // Table geometry.
    localparam int SEQ_COUNT = 8;
    localparam int MAX_STEPS = 8;
    localparam int PIN_BITS  = 8;

    localparam int SEQ_W  = $clog2(SEQ_COUNT);
    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int ADDR_W = SEQ_W + STEP_W;
    localparam int SLOTS  = SEQ_COUNT * MAX_STEPS;

    // Fixed field widths on the channels.
    localparam int CMD_W   = 2;
    localparam int PIN_W   = 8;
    localparam int FSEQ_W  = 3;
    localparam int FSTEP_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_COMPLETE = 2'd2,
        CMD_UNUSED   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_ADD,
        REQ_REMOVE,
        REQ_COMPLETE
    } req_kind_t;

    typedef enum logic [1:0] {
        EMIT_FAIL,
        EMIT_SLOT,
        EMIT_EMPTY,
        EMIT_ROUTE
    } emit_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_STEP,
        ST_SHIFT_WR,
        ST_TRIG,
        ST_EMIT_SLOT,
        ST_EMIT_FAIL,
        ST_COMP_RD0,
        ST_COMP_CHK0,
        ST_COMP_RD,
        ST_COMP_CHK,
        ST_EMIT_EMPTY,
        ST_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic       load;
        logic       scan_inc;
        logic       rd_scan;
        logic       rd_next;
        logic       wr_pin;
        logic       wr_shift;
        logic       wr_zero;
        logic       hit_load;
        logic       cur_load;
        logic       trig_eval;
        logic       emit;
        emit_kind_t emit_kind;
        logic       emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      slot_hit;
        logic      data_zero;
        logic      scan_last;
        logic      step_last;
        logic      j_last;
        logic      out_free;
        logic      running;
    } dp_status_t;

    // Usable steps of a sequence: 8 when index mod 4 is 0, 1 when it is 3, else 4.
    function automatic logic [STEP_W:0] seq_depth(input logic [SEQ_W-1:0] seq);
        logic [1:0] k;
        int         d;
        k = 2'(seq);
        d = (k == 2'd0) ? 8 : ((k == 2'd3) ? 1 : 4);
        if (d > MAX_STEPS) begin
            d = MAX_STEPS;
        end
        return (STEP_W + 1)'(d);
    endfunction

endpackage

// File: src/csas_channels.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on csas_pkg for field widths.

interface csas_req_if;
    import csas_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PIN_W-1:0]    pin_ident;
    logic [FSEQ_W-1:0]   done_sequence;

    modport source (output valid, output command, output pin_ident, output done_sequence,
                    input ready);
    modport sink   (input valid, input command, input pin_ident, input done_sequence,
                    output ready);
endinterface

interface csas_rsp_if;
    import csas_pkg::*;

    logic                valid;
    logic                ready;
    logic                success;
    logic [FSEQ_W-1:0]   slot_sequence;
    logic [FSTEP_W-1:0]  slot_step;
    logic [PIN_W-1:0]    routed_pin;
    logic                routed_valid;
    logic                trigger_valid;
    logic [FSEQ_W-1:0]   trigger_sequence;
    logic                running_now;
    logic                last_result;

    modport source (output valid, output success, output slot_sequence, output slot_step,
                    output routed_pin, output routed_valid, output trigger_valid,
                    output trigger_sequence, output running_now, output last_result,
                    input ready);
    modport sink   (input valid, input success, input slot_sequence, input slot_step,
                    input routed_pin, input routed_valid, input trigger_valid,
                    input trigger_sequence, input running_now, input last_result,
                    output ready);
endinterface

// File: src/csas_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module csas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: src/csas_ctrl.sv
// Sequencing state machine: scans, shifts, triggers and emits result words.
// Depends on csas_pkg; drives csas_datapath through ctrl_cmd_t.

module csas_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  csas_pkg::dp_status_t  status,
    output csas_pkg::ctrl_cmd_t   cmd
);
    import csas_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = EMIT_FAIL;
        req_ready     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (status.kind)
                    REQ_ADD:      state_next = ST_SCAN_RD;
                    REQ_REMOVE:   state_next = ST_SCAN_RD;
                    REQ_COMPLETE: state_next = ST_COMP_RD0;
                    default:      state_next = ST_EMIT_FAIL;
                endcase
            end

            ST_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (status.slot_hit)
                begin
                    if (status.kind == REQ_ADD)
                    begin
                        cmd.wr_pin = 1'b1;
                        state_next = ST_TRIG;
                    end
                    else
                    begin
                        cmd.hit_load = 1'b1;
                        state_next   = ST_SHIFT_STEP;
                    end
                end
                else if (status.scan_last)
                begin
                    state_next = ST_EMIT_FAIL;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
            end

            ST_SHIFT_STEP:
            begin
                if (status.j_last)
                begin
                    cmd.wr_zero = 1'b1;
                    state_next  = ST_TRIG;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = ST_SHIFT_STEP;
            end

            ST_TRIG:
            begin
                // An add only starts a sequence when conversion is idle.
                cmd.trig_eval = (status.kind == REQ_REMOVE) || !status.running;
                state_next    = ST_EMIT_SLOT;
            end

            ST_EMIT_SLOT:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_SLOT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_EMIT_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_FAIL;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_COMP_RD0:
            begin
                cmd.rd_scan   = 1'b1;
                cmd.trig_eval = 1'b1;
                state_next    = ST_COMP_CHK0;
            end

            ST_COMP_CHK0:
            begin
                if (status.data_zero)
                begin
                    state_next = ST_EMIT_EMPTY;
                end
                else
                begin
                    cmd.cur_load = 1'b1;
                    if (status.step_last)
                    begin
                        state_next = ST_EMIT_LAST;
                    end
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                        state_next   = ST_COMP_RD;
                    end
                end
            end

            ST_COMP_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_COMP_CHK;
            end

            ST_COMP_CHK:
            begin
                // The step just read decides whether the held step is the last one.
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_ROUTE;
                    cmd.emit_last = status.data_zero;
                    if (status.data_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cur_load = 1'b1;
                        if (status.step_last)
                        begin
                            state_next = ST_EMIT_LAST;
                        end
                        else
                        begin
                            cmd.scan_inc = 1'b1;
                            state_next   = ST_COMP_RD;
                        end
                    end
                end
            end

            ST_EMIT_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_EMPTY;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_EMIT_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_ROUTE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: src/csas_datapath.sv
// Slot table storage, scan and shift addressing, round-robin trigger search and
// the result word register. Depends on csas_pkg, csas_ram and csas_rsp_if.

module csas_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [csas_pkg::CMD_W-1:0]    req_command,
    input  logic [csas_pkg::PIN_W-1:0]    req_pin_ident,
    input  logic [csas_pkg::FSEQ_W-1:0]   req_done_sequence,
    csas_rsp_if.source                    rsp,
    input  csas_pkg::ctrl_cmd_t           cmd,
    output csas_pkg::dp_status_t          status
);
    import csas_pkg::*;

    req_kind_t           kind_reg;
    logic [PIN_BITS-1:0] pin_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [STEP_W-1:0]   j_reg;
    logic [PIN_BITS-1:0] cur_pin_reg;
    logic [STEP_W-1:0]   cur_step_reg;
    logic [SLOTS-1:0]    written_reg;
    logic [SEQ_COUNT-1:0] head_reg;
    logic                running_reg;
    logic                trig_valid_reg;
    logic [SEQ_W-1:0]    trig_seq_reg;
    logic                rd_written_reg;

    logic                out_valid_reg;
    logic                out_success_reg;
    logic [FSEQ_W-1:0]   out_seq_reg;
    logic [FSTEP_W-1:0]  out_step_reg;
    logic [PIN_W-1:0]    out_pin_reg;
    logic                out_rvalid_reg;
    logic                out_tvalid_reg;
    logic [FSEQ_W-1:0]   out_tseq_reg;
    logic                out_run_reg;
    logic                out_last_reg;

    logic [SEQ_W-1:0]    idx_seq;
    logic [STEP_W-1:0]   idx_step;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   waddr;
    logic [PIN_BITS-1:0] wdata;
    logic                we;
    logic                re;
    logic [PIN_BITS-1:0] ram_rdata;
    logic [PIN_BITS-1:0] rdata;
    logic [STEP_W-1:0]   wstep;
    logic [SEQ_W-1:0]    wseq;
    command_t            in_cmd;
    logic [PIN_BITS-1:0] in_pin;
    logic                in_seq_ok;
    req_kind_t           in_kind;
    logic                trig_found;
    logic [SEQ_W-1:0]    trig_seq;
    logic [SEQ_W:0]      cand;
    logic                route_last;

    assign idx_seq  = idx_reg[ADDR_W-1:STEP_W];
    assign idx_step = idx_reg[STEP_W-1:0];

    // Request decode at load time.
    assign in_cmd    = command_t'(req_command);
    assign in_pin    = req_pin_ident[PIN_BITS-1:0];
    assign in_seq_ok = ({1'b0, req_done_sequence} < (FSEQ_W + 1)'(SEQ_COUNT));

    always_comb
    begin
        case (in_cmd)
            CMD_ADD:      in_kind = (in_pin != '0) ? REQ_ADD : REQ_NONE;
            CMD_REMOVE:   in_kind = (in_pin != '0) ? REQ_REMOVE : REQ_NONE;
            CMD_COMPLETE: in_kind = in_seq_ok ? REQ_COMPLETE : REQ_NONE;
            default:      in_kind = REQ_NONE;
        endcase
    end

    // Table memory; an entry never written since reset reads as empty.
    assign re    = cmd.rd_scan || cmd.rd_next;
    assign raddr = cmd.rd_next ? {idx_seq, j_reg + STEP_W'(1)} : idx_reg;
    assign we    = cmd.wr_pin || cmd.wr_shift || cmd.wr_zero;

    always_comb
    begin
        waddr = idx_reg;
        wdata = pin_reg;
        if (cmd.wr_shift)
        begin
            waddr = {idx_seq, j_reg};
            wdata = rdata;
        end
        else if (cmd.wr_zero)
        begin
            waddr = {idx_seq, STEP_W'(MAX_STEPS - 1)};
            wdata = '0;
        end
    end

    assign wstep = waddr[STEP_W-1:0];
    assign wseq  = waddr[ADDR_W-1:STEP_W];

    csas_ram #(
        .WIDTH (PIN_BITS),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign rdata = rd_written_reg ? ram_rdata : '0;

    // Round-robin search from the sequence after idx_seq, ending at idx_seq itself.
    always_comb
    begin
        trig_found = 1'b0;
        trig_seq   = '0;
        cand       = '0;
        for (int i = SEQ_COUNT; i >= 1; i--)
        begin
            cand = {1'b0, idx_seq} + (SEQ_W + 1)'(i);
            if (cand >= (SEQ_W + 1)'(SEQ_COUNT))
            begin
                cand = cand - (SEQ_W + 1)'(SEQ_COUNT);
            end
            if (head_reg[cand[SEQ_W-1:0]])
            begin
                trig_found = 1'b1;
                trig_seq   = cand[SEQ_W-1:0];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= REQ_NONE;
            written_reg    <= '0;
            head_reg       <= '0;
            running_reg    <= 1'b0;
            trig_valid_reg <= 1'b0;
            trig_seq_reg   <= '0;
            rd_written_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg       <= in_kind;
                trig_valid_reg <= 1'b0;
                trig_seq_reg   <= '0;
            end
            if (we)
            begin
                written_reg[waddr] <= 1'b1;
                if (wstep == '0)
                begin
                    head_reg[wseq] <= (wdata != '0);
                end
            end
            if (re)
            begin
                rd_written_reg <= written_reg[raddr];
            end
            if (cmd.trig_eval)
            begin
                trig_valid_reg <= trig_found;
                trig_seq_reg   <= trig_found ? trig_seq : '0;
                running_reg    <= trig_found;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    assign route_last = cmd.emit_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pin_reg <= in_pin;
            idx_reg <= (in_cmd == CMD_COMPLETE) ?
                       {req_done_sequence[SEQ_W-1:0], STEP_W'(0)} : '0;
        end
        else if (cmd.scan_inc)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (cmd.hit_load)
        begin
            j_reg <= idx_step;
        end
        else if (cmd.wr_shift)
        begin
            j_reg <= j_reg + STEP_W'(1);
        end
        if (cmd.cur_load)
        begin
            cur_pin_reg  <= rdata;
            cur_step_reg <= idx_step;
        end
        if (cmd.emit)
        begin
            out_last_reg <= cmd.emit_last;
            out_run_reg  <= running_reg;
            case (cmd.emit_kind)
                EMIT_SLOT:
                begin
                    out_success_reg <= 1'b1;
                    out_seq_reg     <= FSEQ_W'(idx_seq);
                    out_step_reg    <= FSTEP_W'(idx_step);
                    out_pin_reg     <= '0;
                    out_rvalid_reg  <= 1'b0;
                    out_tvalid_reg  <= trig_valid_reg;
                    out_tseq_reg    <= FSEQ_W'(trig_seq_reg);
                end
                EMIT_EMPTY:
                begin
                    out_success_reg <= 1'b1;
                    out_seq_reg     <= FSEQ_W'(idx_seq);
                    out_step_reg    <= '0;
                    out_pin_reg     <= '0;
                    out_rvalid_reg  <= 1'b0;
                    out_tvalid_reg  <= trig_valid_reg;
                    out_tseq_reg    <= FSEQ_W'(trig_seq_reg);
                end
                EMIT_ROUTE:
                begin
                    // Only the final routed step carries the trigger.
                    out_success_reg <= 1'b1;
                    out_seq_reg     <= FSEQ_W'(idx_seq);
                    out_step_reg    <= FSTEP_W'(cur_step_reg);
                    out_pin_reg     <= PIN_W'(cur_pin_reg);
                    out_rvalid_reg  <= 1'b1;
                    out_tvalid_reg  <= route_last && trig_valid_reg;
                    out_tseq_reg    <= route_last ? FSEQ_W'(trig_seq_reg) : '0;
                end
                default:
                begin
                    out_success_reg <= 1'b0;
                    out_seq_reg     <= '0;
                    out_step_reg    <= '0;
                    out_pin_reg     <= '0;
                    out_rvalid_reg  <= 1'b0;
                    out_tvalid_reg  <= 1'b0;
                    out_tseq_reg    <= '0;
                end
            endcase
        end
    end

    // running_now is captured with each word, so a held word keeps its value while
    // the next request already updates the running flag.
    assign rsp.valid            = out_valid_reg;
    assign rsp.success          = out_success_reg;
    assign rsp.slot_sequence    = out_seq_reg;
    assign rsp.slot_step        = out_step_reg;
    assign rsp.routed_pin       = out_pin_reg;
    assign rsp.routed_valid     = out_rvalid_reg;
    assign rsp.trigger_valid    = out_tvalid_reg;
    assign rsp.trigger_sequence = out_tseq_reg;
    assign rsp.running_now      = out_run_reg;
    assign rsp.last_result      = out_last_reg;

    // Status back to the controller.
    always_comb
    begin
        status.kind      = kind_reg;
        status.data_zero = (rdata == '0);
        status.slot_hit  = (kind_reg == REQ_ADD) ?
                           ((rdata == '0) && ({1'b0, idx_step} < seq_depth(idx_seq))) :
                           (rdata == pin_reg);
        status.scan_last = (idx_reg == ADDR_W'(SLOTS - 1));
        status.step_last = (idx_step == STEP_W'(MAX_STEPS - 1));
        status.j_last    = (j_reg == STEP_W'(MAX_STEPS - 1));
        status.out_free  = !out_valid_reg || rsp.ready;
        status.running   = running_reg;
    end
endmodule

// File: src/conversion_slot_allocator_scheduler_top.sv
// Top level of the conversion slot allocator and round-robin scheduler.
// Depends on csas_pkg, csas_channels (csas_req_if, csas_rsp_if), csas_ctrl, csas_datapath.
//
// Usage. Request words arrive on req (command, pin_ident, done_sequence) and
// result words leave on rsp; both are valid/ready channels, and a word moves on a
// rising edge with valid and ready high. The block holds a table of 8 sequences by
// 8 step slots in a 64-entry RAM with one read and one write port.
// An add or remove produces exactly one result word. A completion produces one
// word per occupied step of that sequence, in step order, or a single word for an
// empty sequence; last_result marks the final word of every request.
// Sequencing. The block works on one request at a time and takes the
// next one only once the final word of the previous request is in the output
// register. The table scan reads each slot from RAM and then compares it, in index
// order; an add or remove stops at the first hit, and a scan that finds nothing
// reports a failure. A removal then shifts every later step of its sequence down
// one place and writes a zero into the last step. A completion reads the steps of
// its sequence in order until an empty step or the last step.
// Reset. rst_n clears the table at once through per-slot written flags, clears the
// running flag and empties the output register; no clearing sweep is needed.
// Stalls. A result word waits in the output register while rsp.ready is low, and
// the controller holds its position until the register frees up.

module conversion_slot_allocator_scheduler_top (
    input  logic       clk,
    input  logic       rst_n,
    csas_req_if.sink   req,
    csas_rsp_if.source rsp
);
    import csas_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;
    logic       ctrl_ready;

    assign req.ready = ctrl_ready;

    // The controller sequences the scan, shift and emit steps.
    csas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    // The datapath owns the table, the trigger search and the result register.
    csas_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_command       (req.command),
        .req_pin_ident     (req.pin_ident),
        .req_done_sequence (req.done_sequence),
        .rsp               (rsp),
        .cmd               (ctrl_cmd),
        .status            (dp_status)
    );
endmodule

// File: tb/tb_conversion_slot_allocator_scheduler_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for conversion_slot_allocator_scheduler_top: directed and random
// command words, randomly stalled on both channels, checked against an in-bench scheduler.
// Depends on csas_pkg, csas_req_if, csas_rsp_if and the top level itself.

module tb_conversion_slot_allocator_scheduler_top;
    import csas_pkg::*;

    // Run limits. The slowest word is a removal that scans the whole table and then
    // shifts a full sequence down, plus the longest gap on each side.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_JOBS    = 480;
    localparam int POOL_SIZE      = 16;

    // One request word waiting to be sent, with the idle gap that precedes it and a
    // flag that holds it back until every result word already owed has arrived.
    typedef struct packed {
        command_t            cmd;
        logic [PIN_W-1:0]    pin;
        logic [FSEQ_W-1:0]   dseq;
        logic [7:0]          gap;
        logic                drain;
    } job_t;

    // One result word, laid out field by field as the result channel carries it.
    typedef struct packed {
        logic                success;
        logic [FSEQ_W-1:0]   seq;
        logic [FSTEP_W-1:0]  step;
        logic [PIN_W-1:0]    pin;
        logic                routed;
        logic                trig;
        logic [FSEQ_W-1:0]   trig_seq;
        logic                running;
        logic                last_word;
    } route_word_t;

    // Traffic mixes for the random part; each phase favors one kind of command.
    typedef enum int {
        MIX_FILL,
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } traffic_mix_t;

    logic clk = 1'b0;
    logic rst_n;

    csas_req_if req_ch();
    csas_rsp_if rsp_ch();

    conversion_slot_allocator_scheduler_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Scheduler state as the block should hold it: the pin table and the running flag.
    logic [PIN_BITS-1:0] pin_slots [SEQ_COUNT][MAX_STEPS];
    logic                conv_running;

    job_t        request_jobs [$];
    route_word_t awaited_words [$];
    logic [PIN_W-1:0] pin_pool [POOL_SIZE];

    int words_issued    = 0;
    int words_taken     = 0;
    int send_gap_left   = 0;
    int send_calm       = 0;
    int sink_stall_left = 0;
    int sink_calm_left  = 0;
    int stall_cycles    = 0;
    int mismatch_count  = 0;

    // Usable steps of a sequence, decided by its index mod 4 and clamped to the table.
    function automatic int steps_of(input int s);
        int d;
        case (s % 4)
            0:       d = 8;
            3:       d = 1;
            default: d = 4;
        endcase
        return (d > MAX_STEPS) ? MAX_STEPS : d;
    endfunction

    // Round-robin search for the next sequence to convert, starting after 'from' and
    // ending with 'from' itself. The running flag follows whether one was found.
    task automatic start_next(input int from, output logic found,
                              output logic [FSEQ_W-1:0] which);
        int s;
        int i;
        found = 1'b0;
        which = '0;
        s = from;
        for (i = 0; i < SEQ_COUNT; i++) begin
            s = (s + 1) % SEQ_COUNT;
            if (!found && pin_slots[s][0] != '0) begin
                found = 1'b1;
                which = s[FSEQ_W-1:0];
            end
        end
        conv_running = found;
    endtask

    // Applies one accepted request word to the scheduler state and queues the result
    // words that the block owes for it, in the order they must leave.
    task automatic predict_schedule(input command_t cmd, input logic [PIN_W-1:0] pin,
                                    input logic [FSEQ_W-1:0] dseq);
        route_word_t w;
        logic        tv;
        logic [FSEQ_W-1:0] ts;
        logic        hit;
        int          s;
        int          st;
        int          hs;
        int          hst;
        int          n;
        int          j;
        w   = '0;
        tv  = 1'b0;
        ts  = '0;
        hit = 1'b0;
        hs  = 0;
        hst = 0;
        if ((cmd == CMD_ADD || cmd == CMD_REMOVE) && pin != '0) begin
            // An add looks for an empty slot within each sequence's depth, a removal
            // looks for the pin anywhere; both take the first match in table order.
            for (s = 0; s < SEQ_COUNT; s++) begin
                for (st = 0; st < ((cmd == CMD_ADD) ? steps_of(s) : MAX_STEPS); st++) begin
                    if (!hit && pin_slots[s][st] == ((cmd == CMD_ADD) ? '0 : pin)) begin
                        hit = 1'b1;
                        hs  = s;
                        hst = st;
                    end
                end
            end
            if (hit) begin
                if (cmd == CMD_ADD) begin
                    pin_slots[hs][hst] = pin;
                    if (!conv_running) begin
                        start_next(hs, tv, ts);
                    end
                end else begin
                    // Later steps move down one place to close the hole.
                    for (j = hst; j < MAX_STEPS - 1; j++) begin
                        pin_slots[hs][j] = pin_slots[hs][j + 1];
                    end
                    pin_slots[hs][MAX_STEPS - 1] = '0;
                    start_next(hs, tv, ts);
                end
                w.success   = 1'b1;
                w.seq       = hs[FSEQ_W-1:0];
                w.step      = hst[FSTEP_W-1:0];
                w.trig      = tv;
                w.trig_seq  = ts;
                w.running   = conv_running;
                w.last_word = 1'b1;
                awaited_words.push_back(w);
            end
        end else if (cmd == CMD_COMPLETE && int'(dseq) < SEQ_COUNT) begin
            hit = 1'b1;
            n = 0;
            while (n < MAX_STEPS && pin_slots[dseq][n] != '0) begin
                n++;
            end
            start_next(int'(dseq), tv, ts);
            if (n == 0) begin
                // An empty sequence still reports once and carries the trigger.
                w.success   = 1'b1;
                w.seq       = dseq;
                w.trig      = tv;
                w.trig_seq  = ts;
                w.running   = conv_running;
                w.last_word = 1'b1;
                awaited_words.push_back(w);
            end else begin
                for (j = 0; j < n; j++) begin
                    w           = '0;
                    w.success   = 1'b1;
                    w.seq       = dseq;
                    w.step      = j[FSTEP_W-1:0];
                    w.pin       = pin_slots[dseq][j];
                    w.routed    = 1'b1;
                    w.running   = conv_running;
                    if (j == n - 1) begin
                        w.trig      = tv;
                        w.trig_seq  = ts;
                        w.last_word = 1'b1;
                    end
                    awaited_words.push_back(w);
                end
            end
        end
        if (!hit) begin
            // Failed adds and removals, and the unused command, leave the table alone.
            w           = '0;
            w.running   = conv_running;
            w.last_word = 1'b1;
            awaited_words.push_back(w);
        end
    endtask

    function automatic string show_word(input route_word_t w);
        return $sformatf("ok=%0b seq=%0d step=%0d pin=%02h routed=%0b trig=%0b/%0d run=%0b last=%0b",
                         w.success, w.seq, w.step, w.pin, w.routed, w.trig, w.trig_seq,
                         w.running, w.last_word);
    endfunction

    // Queues a request word. Most gaps are short, a few are long, and now and then a
    // stretch of back-to-back words follows.
    task automatic push_job(input command_t c, input logic [PIN_W-1:0] p,
                            input logic [FSEQ_W-1:0] d, input logic drain);
        job_t job;
        int   r;
        int   g;
        g = 0;
        if (send_calm > 0) begin
            send_calm--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                g = 0;
            end else if (r < 88) begin
                g = $urandom_range(1, 3);
            end else if (r < 97) begin
                g = $urandom_range(8, 40);
            end else begin
                send_calm = $urandom_range(20, 60);
            end
        end
        job.cmd   = c;
        job.pin   = p;
        job.dseq  = d;
        job.gap   = g[7:0];
        job.drain = drain;
        request_jobs.push_back(job);
    endtask

    // Pins come mostly from a small pool, so removals hit and duplicates occur.
    function automatic logic [PIN_W-1:0] pick_pin();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            v = 0;
        end else if (r < 75) begin
            v = pin_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            v = $urandom_range(1, 255);
        end
        return v[PIN_W-1:0];
    endfunction

    // Request driver: presents the next queued word at the falling edge once the
    // previous one has been taken and its gap has passed.
    always @(negedge clk) begin : request_driver
        job_t job;
        if (rst_n && words_issued == words_taken) begin
            if (send_gap_left > 0) begin
                req_ch.valid <= 1'b0;
                send_gap_left--;
            end else if (request_jobs.size() != 0 &&
                         !(request_jobs[0].drain && awaited_words.size() != 0)) begin
                job = request_jobs.pop_front();
                req_ch.command       <= job.cmd;
                req_ch.pin_ident     <= job.pin;
                req_ch.done_sequence <= job.dseq;
                req_ch.valid         <= 1'b1;
                words_issued++;
                send_gap_left = (request_jobs.size() != 0) ? int'(request_jobs[0].gap) : 0;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: short and long stalls at random, with calm stretches between.
    always @(negedge clk) begin : result_ready_driver
        int r;
        if (sink_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            sink_stall_left--;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (sink_calm_left > 0) begin
                sink_calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    sink_stall_left = $urandom_range(1, 3);
                end else if (r < 23) begin
                    sink_stall_left = $urandom_range(10, 40);
                end else if (r < 25) begin
                    sink_calm_left = $urandom_range(30, 80);
                end
            end
        end
    end

    // Monitor: every accepted request word updates the predicted state, and every
    // accepted result word is checked against the oldest word still owed.
    always @(posedge clk) begin : word_monitor
        route_word_t seen;
        route_word_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                predict_schedule(command_t'(req_ch.command), req_ch.pin_ident,
                                 req_ch.done_sequence);
                words_taken++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.success   = rsp_ch.success;
                seen.seq       = rsp_ch.slot_sequence;
                seen.step      = rsp_ch.slot_step;
                seen.pin       = rsp_ch.routed_pin;
                seen.routed    = rsp_ch.routed_valid;
                seen.trig      = rsp_ch.trigger_valid;
                seen.trig_seq  = rsp_ch.trigger_sequence;
                seen.running   = rsp_ch.running_now;
                seen.last_word = rsp_ch.last_result;
                if (awaited_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with none owed, expected nothing, actual %s",
                             $time, show_word(seen));
                end else begin
                    want = awaited_words.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        $display("%0t: result word mismatch, expected %s, actual %s",
                                 $time, show_word(want), show_word(seen));
                    end
                end
            end
            // The watchdog counts cycles in which no word moves on either channel.
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : run_control
        traffic_mix_t       mix;
        command_t           cmd;
        logic [FSEQ_W-1:0]  dseq;
        int                 i;
        int                 s;
        int                 rnd;
        int                 phase_left;
        int                 settle;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ADD;
        req_ch.pin_ident     = '0;
        req_ch.done_sequence = '0;
        rsp_ch.ready         = 1'b0;
        conv_running         = 1'b0;
        for (s = 0; s < SEQ_COUNT; s++) begin
            for (i = 0; i < MAX_STEPS; i++) begin
                pin_slots[s][i] = '0;
            end
        end
        pin_pool[0] = 8'hFF;
        pin_pool[1] = 8'h01;
        for (i = 2; i < POOL_SIZE; i++) begin
            rnd = $urandom_range(1, 255);
            pin_pool[i] = rnd[PIN_W-1:0];
        end

        // Directed part. On the empty table: zero pin on add and remove, a pin that is
        // not there, an empty sequence completed with nothing to start, and the unused
        // command with every bit set.
        push_job(CMD_ADD, 8'h00, 3'd0, 1'b0);
        push_job(CMD_REMOVE, 8'h00, 3'd0, 1'b0);
        push_job(CMD_REMOVE, 8'h55, 3'd0, 1'b0);
        push_job(CMD_COMPLETE, 8'h00, 3'd0, 1'b0);
        push_job(CMD_UNUSED, 8'hFF, 3'd7, 1'b0);
        // The first add starts sequence 0 by wrapping round to itself; later adds
        // while running start nothing.
        push_job(CMD_ADD, 8'hFF, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h01, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h80, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h7F, 3'd0, 1'b0);
        // Completion with several occupied steps, then a removal from the middle
        // that compacts the sequence, then the shorter completion.
        push_job(CMD_COMPLETE, 8'h00, 3'd0, 1'b1);
        push_job(CMD_REMOVE, 8'h80, 3'd0, 1'b0);
        push_job(CMD_COMPLETE, 8'h00, 3'd0, 1'b0);
        // Fill sequence 0 to its full depth, so the next add spills into sequence 1.
        push_job(CMD_ADD, 8'hAA, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h55, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h0F, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'hF0, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'h33, 3'd0, 1'b0);
        push_job(CMD_ADD, 8'hC3, 3'd0, 1'b0);
        // Completing the last sequence wraps the search round to sequence 0.
        push_job(CMD_COMPLETE, 8'h00, 3'd7, 1'b0);
        push_job(CMD_COMPLETE, 8'h00, 3'd1, 1'b0);
        // Removing step 0 shifts a full sequence down; emptying sequence 1 hands
        // the conversion back to sequence 0.
        push_job(CMD_REMOVE, 8'hFF, 3'd0, 1'b0);
        push_job(CMD_REMOVE, 8'hC3, 3'd0, 1'b0);
        push_job(CMD_COMPLETE, 8'h00, 3'd0, 1'b0);

        // Random part, in phases. It opens by filling the table past full and then
        // drains it; after that the mix changes from phase to phase.
        mix        = MIX_FILL;
        phase_left = 40;
        for (i = 0; i < RANDOM_JOBS; i++) begin
            if (phase_left == 0) begin
                if (mix == MIX_FILL) begin
                    mix        = MIX_SHRINK;
                    phase_left = 70;
                end else begin
                    rnd        = $urandom_range(0, 9);
                    mix        = (rnd < 2) ? MIX_FILL : (rnd < 5) ? MIX_GROW :
                                 (rnd < 7) ? MIX_SHRINK : MIX_EVEN;
                    phase_left = (mix == MIX_FILL) ? 40 : $urandom_range(20, 60);
                end
            end
            phase_left--;
            rnd = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:   cmd = (rnd < 95) ? CMD_ADD : CMD_COMPLETE;
                MIX_GROW:   cmd = (rnd < 60) ? CMD_ADD : (rnd < 85) ? CMD_COMPLETE :
                                  (rnd < 95) ? CMD_REMOVE : CMD_UNUSED;
                MIX_SHRINK: cmd = (rnd < 10) ? CMD_ADD : (rnd < 40) ? CMD_COMPLETE :
                                  (rnd < 95) ? CMD_REMOVE : CMD_UNUSED;
                default:    cmd = (rnd < 35) ? CMD_ADD : (rnd < 65) ? CMD_REMOVE :
                                  (rnd < 95) ? CMD_COMPLETE : CMD_UNUSED;
            endcase
            rnd  = $urandom_range(0, SEQ_COUNT - 1);
            dseq = rnd[FSEQ_W-1:0];
            // The first random word, and a few more, wait until the block has
            // delivered everything it owes.
            push_job(cmd, pick_pin(), dseq, (i == 0) || ($urandom_range(0, 49) == 0));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((request_jobs.size() != 0 || words_issued != words_taken ||
                awaited_words.size() != 0) && stall_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
        end
        // Let any stray word show up before the verdict.
        settle = 0;
        while (settle < SETTLE_CYCLES && stall_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
            settle++;
        end

        if (stall_cycles < WATCHDOG_LIMIT && mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/csas_pkg.sv
src/csas_channels.sv
src/csas_ram.sv
src/csas_ctrl.sv
src/csas_datapath.sv
src/conversion_slot_allocator_scheduler_top.sv
tb/tb_conversion_slot_allocator_scheduler_top.sv
